// ===== hdl/blist_pkg.sv =====
package blist_pkg;

	// list capacity and derived widths
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int FUNC_W = 3;
	localparam int DATA_W = 32;
	localparam int POS_W  = 5;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 5;

	typedef logic [FUNC_W-1:0]        func_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [STAT_W-1:0]        stat_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	// operation codes
	localparam func_t FN_INS_FRONT = 3'd0;
	localparam func_t FN_APPEND    = 3'd1;
	localparam func_t FN_RM_FRONT  = 3'd2;
	localparam func_t FN_RM_POS    = 3'd3;
	localparam func_t FN_DUMP      = 3'd4;

	// status codes
	localparam stat_t STAT_OK    = 2'd0;
	localparam stat_t STAT_FULL  = 2'd1;
	localparam stat_t STAT_EMPTY = 2'd2;
	localparam stat_t STAT_RANGE = 2'd3;

	// per-cell load select
	typedef logic [2:0] cell_op_t;
	localparam cell_op_t COP_HOLD = 3'd0;
	localparam cell_op_t COP_LOAD = 3'd1;
	localparam cell_op_t COP_PREV = 3'd2;
	localparam cell_op_t COP_NEXT = 3'd3;
	localparam cell_op_t COP_HEAD = 3'd4;

endpackage

// ===== hdl/blist_if.sv =====
interface blist_req_if import blist_pkg::*; ();
	logic  valid;
	logic  ready;
	func_t func;
	data_t value;
	pos_t  position;

	modport source (output valid, output func, output value, output position, input ready);
	modport sink (input valid, input func, input value, input position, output ready);
endinterface

interface blist_rsp_if import blist_pkg::*; ();
	logic  valid;
	logic  ready;
	stat_t status;
	len_t  length;
	data_t element;
	logic  last;

	modport source (output valid, output status, output length, output element, output last,
		input ready);
	modport sink (input valid, input status, input length, input element, input last,
		output ready);
endinterface

// ===== hdl/blist_cell.sv =====
module blist_cell import blist_pkg::*; (
	input  logic     clk,
	input  cell_op_t op,
	input  data_t    ins,
	input  data_t    prev,
	input  data_t    next,
	input  data_t    head,
	output data_t    q
);

	data_t val_q;

	// one list slot: hold, load a new item, take a neighbor or take the head
	always_ff @(posedge clk) begin
		case (op)
			COP_LOAD: val_q <= ins;
			COP_PREV: val_q <= prev;
			COP_NEXT: val_q <= next;
			COP_HEAD: val_q <= head;
			default:  val_q <= val_q;
		endcase
	end

	assign q = val_q;

endmodule

// ===== hdl/bounded_positional_list.sv =====
// channel | dir | fields                              | accepted when
// req     | in  | func, value, position               | req.valid && req.ready
// rsp     | out | status, length, element, last       | rsp.valid && rsp.ready
//
// inserts and removals update the affected cells of the chain in parallel
// a dump emits each element from the head while the output is free, the chain rotating
// its occupied cells toward the head so it is back in order after the last one
// req is taken only while no dump runs and the output register is free or being taken
// arst_n clears the length and the output valid; cell contents come up unknown
module bounded_positional_list import blist_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	blist_req_if.sink req,
	blist_rsp_if.source rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;
	localparam int   EXT_W  = CNT_W + POS_W;

	logic  state_q;
	cnt_t  count_q;
	cnt_t  dptr_q;

	logic  ov_q;
	stat_t status_q;
	len_t  length_q;
	data_t element_q;
	logic  last_q;

	data_t    cell_q [DEPTH];
	cell_op_t cop    [DEPTH];

	logic slot_free;
	logic acc;
	logic dump_step;
	logic dump_last;

	// decoded operation
	logic  do_front;
	logic  do_append;
	logic  do_remove;
	logic  start_dump;
	cnt_t  rm_idx;
	cnt_t  n_count;
	stat_t n_status;

	logic [EXT_W-1:0] pos_ext;
	logic [EXT_W-1:0] cnt_ext;

	assign slot_free = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign acc       = req.valid && req.ready;
	assign dump_step = (state_q == S_DUMP) && slot_free;
	assign dump_last = (CNT_W'(dptr_q + 1'b1) == count_q);

	assign pos_ext = EXT_W'(req.position);
	assign cnt_ext = EXT_W'(count_q);

	// operation decode
	always_comb begin
		do_front   = 1'b0;
		do_append  = 1'b0;
		do_remove  = 1'b0;
		start_dump = 1'b0;
		rm_idx     = '0;
		n_count    = count_q;
		n_status   = STAT_OK;
		unique case (req.func) inside
			FN_INS_FRONT, FN_APPEND: begin
				if (count_q == CNT_W'(DEPTH)) begin
					n_status = STAT_FULL;
				end else begin
					do_front  = (req.func == FN_INS_FRONT);
					do_append = (req.func == FN_APPEND);
					n_count   = CNT_W'(count_q + 1'b1);
				end
			end
			FN_RM_FRONT: begin
				if (count_q == '0) begin
					n_status = STAT_EMPTY;
				end else begin
					do_remove = 1'b1;
					n_count   = CNT_W'(count_q - 1'b1);
				end
			end
			FN_RM_POS: begin
				if (count_q == '0) begin
					n_status = STAT_EMPTY;
				end else if (req.position == '0 || pos_ext > cnt_ext) begin
					n_status = STAT_RANGE;
				end else begin
					do_remove = 1'b1;
					rm_idx    = CNT_W'(pos_ext - 1'b1);
					n_count   = CNT_W'(count_q - 1'b1);
				end
			end
			FN_DUMP: begin
				if (count_q == '0) begin
					n_status = STAT_EMPTY;
				end else begin
					start_dump = 1'b1;
				end
			end
			default: n_status = STAT_OK;
		endcase
	end

	// per-cell load selects and the chain itself
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_comb begin
			cop[i] = COP_HOLD;
			if (acc && do_front) begin
				cop[i] = (i == 0) ? COP_LOAD : COP_PREV;
			end else if (acc && do_append && CNT_W'(i) == count_q) begin
				cop[i] = COP_LOAD;
			end else if (acc && do_remove && CNT_W'(i) >= rm_idx && i != DEPTH - 1) begin
				cop[i] = COP_NEXT;
			end else if (dump_step) begin
				if (CNT_W'(i + 1) < count_q) begin
					cop[i] = COP_NEXT;
				end else if (CNT_W'(i + 1) == count_q) begin
					cop[i] = COP_HEAD;
				end
			end
		end

		blist_cell u_cell (
			.clk  (clk),
			.op   (cop[i]),
			.ins  (req.value),
			.prev (cell_q[(i == 0) ? 0 : i - 1]),
			.next (cell_q[(i == DEPTH - 1) ? i : i + 1]),
			.head (cell_q[0]),
			.q    (cell_q[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			dptr_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						count_q <= n_count;
						dptr_q  <= '0;
						if (start_dump) begin
							state_q <= S_DUMP;
							ov_q    <= 1'b0;
						end else begin
							ov_q <= 1'b1;
						end
					end else if (rsp.ready) begin
						ov_q <= 1'b0;
					end
				end
				S_DUMP: begin
					if (dump_step) begin
						ov_q   <= 1'b1;
						dptr_q <= CNT_W'(dptr_q + 1'b1);
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (acc && !start_dump) begin
			status_q  <= n_status;
			length_q  <= LEN_W'(n_count);
			element_q <= '0;
			last_q    <= 1'b1;
		end else if (dump_step) begin
			status_q  <= STAT_OK;
			length_q  <= LEN_W'(count_q);
			element_q <= cell_q[0];
			last_q    <= dump_last;
		end
	end

	assign rsp.valid   = ov_q;
	assign rsp.status  = status_q;
	assign rsp.length  = length_q;
	assign rsp.element = element_q;
	assign rsp.last    = last_q;

endmodule
